FILE: rtl/core/psg_pkg.sv
// Package: shared constants and tables for the tone/noise sound generator.
package psg_pkg;
    localparam logic [29:0] MASTER_STEP = 30'd3579545;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } t_opcode;

    // Attenuation code to volume (table value shifted right by 5).
    function automatic logic [10:0] att_volume(input logic [3:0] att);
        logic [15:0] lvl;
        case (att)
            4'd0:    lvl = 16'hFFFF;
            4'd1:    lvl = 16'hCB30;
            4'd2:    lvl = 16'hA145;
            4'd3:    lvl = 16'h8000;
            4'd4:    lvl = 16'h6598;
            4'd5:    lvl = 16'h50A3;
            4'd6:    lvl = 16'h4000;
            4'd7:    lvl = 16'h32CC;
            4'd8:    lvl = 16'h2851;
            4'd9:    lvl = 16'h2000;
            4'd10:   lvl = 16'h1966;
            4'd11:   lvl = 16'h1428;
            4'd12:   lvl = 16'h1000;
            4'd13:   lvl = 16'h0CB3;
            4'd14:   lvl = 16'h0A14;
            default: lvl = 16'h0000;
        endcase
        return lvl[15:5];
    endfunction

    function automatic logic [15:0] variant_seed(input logic [1:0] v);
        return (v == 2'd0) ? 16'h8000 : 16'h4000;
    endfunction

    function automatic logic [15:0] variant_white(input logic [1:0] v);
        logic [15:0] t;
        case (v)
            2'd0:    t = 16'h9000;
            2'd1:    t = 16'h6000;
            default: t = 16'h4400;
        endcase
        return t;
    endfunction
endpackage

FILE: rtl/core/psg_tone_noise_generator.sv
// Top level: three-tone, one-noise sound generator with a shared subtract unit.
//
//  channel | direction | signals
//  --------+-----------+--------------------------------------------
//  in      | input     | i_valid, o_ready, i_opcode, i_data_byte
//  out     | output    | o_valid, i_ready, o_sample
//  cfg     | input     | i_cfg_we, i_cfg_wdata (chip_variant)
//
// A command write is latched in S_IDLE and decoded in S_WRITE. A tick walks the four channels through
// one shared 30-bit add/compare/subtract unit, one toggle or shift per cycle:
// per channel an add step in S_ADD, one subtract step per threshold crossing and a final
// compare step in S_SUB, then a mix step in S_MIX and an output step in S_OUT.
// At the default rate a channel at period 1 sees up to 11 threshold crossings
// per tick, and the output step waits out any output stall.
// Reset is synchronous, active low. A finished sample sits in the output
// register; the next transaction is accepted meanwhile, but a tick waits
// for the output register to drain before delivering.
module psg_tone_noise_generator
    import psg_pkg::*;
#(
    parameter int SAMPLE_RATE = 22050
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [0:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_sample,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);
    localparam logic [29:0] TH_UNIT = 30'(16 * SAMPLE_RATE);

    typedef enum logic [2:0] {
        S_IDLE, S_WRITE, S_ADD, S_SUB, S_MIX, S_OUT
    } t_state;

    t_state      r_state;
    logic [1:0]  r_variant;
    logic [7:0]  r_latch;
    logic [7:0]  r_byte;
    logic [9:0]  r_tone_period [3];
    logic [9:0]  r_noise_period;
    logic [3:0]  r_att [4];
    logic [29:0] r_phase [4];
    logic [3:0]  r_levels;
    logic [15:0] r_shift;
    logic [15:0] r_tap;
    logic [1:0]  r_rate_mode;
    logic [1:0]  r_ch;
    logic [29:0] r_th;
    logic        r_out_valid;
    logic signed [15:0] r_sample;

    logic [9:0]  w_period;
    logic [29:0] w_th;
    logic [29:0] w_sum;
    logic signed [13:0] w_mix;
    logic [3:0]  w_reg;
    logic [1:0]  w_wch;
    logic [7:0]  w_lat;
    logic [9:0]  w_p;

    // threshold of the channel under work (period up to 1023, fits in 30 bits)
    always_comb begin
        w_period = (r_ch == 2'd3) ? r_noise_period : r_tone_period[r_ch];
        w_th     = 30'(w_period * TH_UNIT);
        w_sum    = r_phase[r_ch] + MASTER_STEP;
    end

    // signed mix of four volumes; range fits +/-8188, no saturation reached
    always_comb begin
        w_mix = '0;
        for (int k = 0; k < 4; k++) begin
            if (r_levels[k]) w_mix = w_mix + 14'(att_volume(r_att[k]));
            else             w_mix = w_mix - 14'(att_volume(r_att[k]));
        end
    end

    // command decode
    always_comb begin
        w_lat = r_byte[7] ? r_byte : r_latch;
        w_reg = w_lat[7:4];
        w_wch = w_reg[2:1];
        w_p   = (w_wch == 2'd3) ? 10'd0 : r_tone_period[w_wch];
        if (r_byte[7]) w_p = {w_p[9:4], w_lat[3:0]};
        else           w_p = {r_byte[5:0], w_p[3:0]};
        if (w_p < 10'd6) w_p = 10'd1;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_variant      <= 2'd0;
            r_latch        <= 8'd0;
            r_noise_period <= 10'd16;
            r_levels       <= 4'hF;
            r_shift        <= variant_seed(2'd0);
            r_tap          <= variant_white(2'd0);
            r_rate_mode    <= 2'd0;
            r_ch           <= 2'd0;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < 3; k++) r_tone_period[k] <= 10'd1;
            for (int k = 0; k < 4; k++) begin
                r_att[k]   <= 4'd15;
                r_phase[k] <= '0;
            end
        end else begin
            if (i_cfg_we) r_variant <= i_cfg_wdata;
            // drained sample; the output state reloads on its own
            if (r_out_valid && i_ready && r_state != S_OUT) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_byte  <= i_data_byte;
                        r_ch    <= 2'd0;
                        r_state <= (i_opcode == OP_TICK) ? S_ADD : S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_latch <= w_lat;
                    if (w_reg[0]) begin
                        r_att[w_wch] <= w_lat[3:0];
                    end else if (w_wch != 2'd3) begin
                        r_tone_period[w_wch] <= w_p;
                        if (w_wch == 2'd2 && r_rate_mode == 2'd3) r_noise_period <= w_p;
                    end else begin
                        r_rate_mode <= w_lat[1:0];
                        r_shift     <= variant_seed(r_variant);
                        r_tap       <= w_lat[2] ? variant_white(r_variant)
                                                : variant_seed(r_variant);
                        r_noise_period <= (w_lat[1:0] == 2'd3) ? r_tone_period[2]
                                          : (10'd16 << w_lat[1:0]);
                    end
                    r_state <= S_IDLE;
                end
                S_ADD: begin
                    r_phase[r_ch] <= w_sum;
                    r_th          <= w_th;
                    r_state       <= S_SUB;
                end
                S_SUB: begin
                    // one threshold crossing per cycle
                    if (r_phase[r_ch] >= r_th) begin
                        r_phase[r_ch] <= r_phase[r_ch] - r_th;
                        if (r_ch != 2'd3) begin
                            r_levels[r_ch] <= ~r_levels[r_ch];
                        end else if (r_shift[0]) begin
                            r_shift     <= (r_shift >> 1) ^ r_tap;
                            r_levels[3] <= 1'b1;
                        end else begin
                            r_shift     <= r_shift >> 1;
                            r_levels[3] <= 1'b0;
                        end
                    end else if (r_ch == 2'd3) begin
                        r_state <= S_MIX;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= S_ADD;
                    end
                end
                S_MIX: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // levels and attenuation hold until the sample is loaded
                    if (!r_out_valid || i_ready) begin
                        r_sample    <= 16'(w_mix);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a new sample is only loaded when the output register is free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_ready) |=> r_state == S_OUT)
        else $error("sample delivered over a pending one");

    // a channel whose phase is below threshold is left for the next channel or the mix
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB && r_phase[r_ch] < r_th) |=> (r_state == S_ADD || r_state == S_MIX))
        else $error("sequencer skipped a channel");

    // ready only when idle, never during a tick
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD || r_state == S_SUB) |-> !o_ready)
        else $error("ready raised during a tick");
endmodule

FILE: tb/tb_psg_tone_noise_generator.sv
// Testbench for the tone/noise sound generator: random command and tick traffic with a predictor.
module tb_psg_tone_noise_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import psg_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 400;
    localparam int DRAIN_WAIT = 80;

    // Predictor and store of expected samples
    class psg_sample_model;
        bit [1:0]  variant;
        bit [7:0]  latch;
        bit [9:0]  tperiod [3];
        bit [9:0]  nperiod;
        bit [3:0]  att [4];
        bit [29:0] acc [4];
        bit [3:0]  levels;
        bit [15:0] lfsr;
        bit [15:0] tap;
        bit [1:0]  nmode;
        logic signed [15:0] sample_q [$];
        int errors;

        function new();
            variant = 0;
            latch   = 0;
            for (int k = 0; k < 3; k++) tperiod[k] = 1;
            nperiod = 16;
            for (int k = 0; k < 4; k++) begin
                att[k] = 15;
                acc[k] = 0;
            end
            levels = 4'hF;
            lfsr   = seed_of(0);
            tap    = white_of(0);
            nmode  = 0;
            errors = 0;
        endfunction

        function bit [15:0] seed_of(bit [1:0] v);
            return (v == 0) ? 16'h8000 : 16'h4000;
        endfunction

        function bit [15:0] white_of(bit [1:0] v);
            case (v)
                2'd0:    return 16'h9000;
                2'd1:    return 16'h6000;
                default: return 16'h4400;
            endcase
        endfunction

        function int volume_of(bit [3:0] a);
            bit [15:0] lvl [16] = '{16'hFFFF, 16'hCB30, 16'hA145, 16'h8000,
                                     16'h6598, 16'h50A3, 16'h4000, 16'h32CC,
                                     16'h2851, 16'h2000, 16'h1966, 16'h1428,
                                     16'h1000, 16'h0CB3, 16'h0A14, 16'h0000};
            return int'(lvl[a] >> 5);
        endfunction

        // Command byte decode
        function void apply_byte(bit [7:0] b);
            bit [3:0] rsel;
            bit [1:0] ch;
            bit [9:0] p;
            if (b[7]) latch = b;
            rsel = latch[7:4];
            ch   = rsel[2:1];
            if (rsel[0]) begin
                att[ch] = latch[3:0];
            end else if (ch < 3) begin
                p = tperiod[ch];
                if (b[7]) p = {p[9:4], latch[3:0]};
                else      p = {b[5:0], p[3:0]};
                if (p < 6) p = 1;
                tperiod[ch] = p;
                if (ch == 2 && nmode == 3) nperiod = p;
            end else begin
                nmode = latch[1:0];
                lfsr  = seed_of(variant);
                tap   = latch[2] ? white_of(variant) : seed_of(variant);
                nperiod = (nmode == 3) ? tperiod[2] : 10'(16 << nmode);
            end
        endfunction

        // Advance accumulators and mix one sample
        function logic signed [15:0] advance();
            bit [31:0] th;
            int sum, v;
            for (int k = 0; k < 4; k++) begin
                th = 32'((k < 3) ? tperiod[k] : nperiod) * 32'd352800;
                acc[k] = acc[k] + MASTER_STEP;
                while ({2'b0, acc[k]} >= th) begin
                    acc[k] = acc[k] - th[29:0];
                    if (k < 3) begin
                        levels[k] = ~levels[k];
                    end else if (lfsr[0]) begin
                        lfsr = (lfsr >> 1) ^ tap;
                        levels[3] = 1'b1;
                    end else begin
                        lfsr = lfsr >> 1;
                        levels[3] = 1'b0;
                    end
                end
            end
            sum = 0;
            for (int k = 0; k < 4; k++) begin
                v = volume_of(att[k]);
                sum += levels[k] ? v : -v;
            end
            if (sum < -32768) sum = -32768;
            if (sum > 32767)  sum = 32767;
            return 16'(sum);
        endfunction

        function void note_item(t_opcode op, bit [7:0] b);
            if (op == OP_TICK) sample_q.push_back(advance());
            else apply_byte(b);
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_sample(logic signed [15:0] got);
            logic signed [15:0] want;
            if (sample_q.size() == 0) begin
                report($sformatf("unexpected sample %0d", got));
            end else begin
                want = sample_q.pop_front();
                if (got !== want)
                    report($sformatf("sample %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [0:0]  i_opcode = OP_WRITE;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [15:0] o_sample;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = 2'd0;

    psg_sample_model model = new();
    int idle_cycles = 0;
    int rx_count = 0;

    psg_tone_noise_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample    (o_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("psg_tone_noise_generator: mismatch");
                $finish;
            end
        end
    end

    // Offer one transaction after a random gap
    task send(t_opcode op, bit [7:0] b);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        model.note_item(op, b);
    endtask

    task send_tick();
        send(OP_TICK, 8'($urandom));
    endtask

    // Drain all samples, let a trailing write settle, then set the variant
    task set_variant(bit [1:0] v);
        i_valid <= 1'b0;
        while (model.sample_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model.variant = v;
    endtask

    // Random traffic: ticks, latch/data pairs, single latch or data bytes and noise writes
    task random_phase(int n);
        int r;
        bit [7:0] b;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            b = 8'($urandom);
            case (r)
                0, 1, 2, 3: send_tick();
                4, 5, 6: begin
                    send(OP_WRITE, b | 8'h80);
                    send(OP_WRITE, b & 8'h7F ^ 8'($urandom_range(0, 127)));
                end
                7: send(OP_WRITE, b | 8'h80);
                8: send(OP_WRITE, b & 8'h7F);
                default: send(OP_WRITE, {5'b11100, b[2:0]});
            endcase
        end
    endtask

    // Result side: random stalls, one long hold-off
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = $urandom_range(0, 12);
            if ($urandom_range(0, 2) == 0) stall = 0;
            if (rx_count == 30) stall = LONG_HOLD;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            model.check_sample(o_sample);
            rx_count++;
        end
    end

    // Main stimulus
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Data byte before any latch: high period bits of channel 0
        send(OP_WRITE, 8'h3F);
        send_tick();
        // Loudest attenuation on every channel
        send(OP_WRITE, 8'h90);
        send(OP_WRITE, 8'hB0);
        send(OP_WRITE, 8'hD0);
        send(OP_WRITE, 8'hF0);
        send_tick();
        // Short periods fold to one, then a long period
        send(OP_WRITE, 8'h85);
        send(OP_WRITE, 8'h00);
        send(OP_WRITE, 8'hAF);
        send(OP_WRITE, 8'h3F);
        send_tick();
        // Noise modes, periodic and white, data after a noise latch
        send(OP_WRITE, 8'hE0);
        send_tick();
        send(OP_WRITE, 8'hE7);
        send(OP_WRITE, 8'h00);
        // Channel 2 period feeds noise in mode 3
        send(OP_WRITE, 8'hC6);
        send(OP_WRITE, 8'h01);
        send_tick();
        send(OP_WRITE, 8'hE5);
        send(OP_WRITE, 8'hFF);
        send_tick();
        send(OP_WRITE, 8'h9F);
        send_tick();

        set_variant(2'd1);
        random_phase(80);
        set_variant(2'd2);
        random_phase(80);
        set_variant(2'd3);
        random_phase(60);
        set_variant(2'd0);
        random_phase(60);
        set_variant(2'd2);
        random_phase(40);

        i_valid <= 1'b0;
        while (model.sample_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (model.errors == 0)
            $display("psg_tone_noise_generator: match");
        else
            $display("psg_tone_noise_generator: mismatch");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/psg_pkg.sv
rtl/core/psg_tone_noise_generator.sv
tb/tb_psg_tone_noise_generator.sv
